// ===== rtl/ecc_pkg.sv =====
// Shared types and constants for the exposure countdown controller.
// Used by ecc_step and exposure_countdown_controller_unit; depends on nothing.
package ecc_pkg;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned PRESS_W  = 17;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned ENC_W    = 16;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [TIME_W-1:0] WARN_SECONDS = TIME_W'(8);

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = CFG_W'(50);
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(2000);

    typedef enum logic [1:0] {
        KIND_MS_TICK  = 2'd0,
        KIND_SEC_TICK = 2'd1,
        KIND_ENC_CAP  = 2'd2,
        KIND_LID      = 2'd3
    } ecc_kind_t;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } ecc_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  seconds_count;
        logic               running;
        logic               buzzer_level;
        logic [PRESS_W-1:0] press_ticks;
        logic               save_pending;
    } ecc_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
    } ecc_cfg_t;

    typedef struct packed {
        ecc_kind_t        kind;
        logic             button_pressed;
        logic             lid_open;
        logic [ENC_W-1:0] encoder_count;
    } ecc_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] seconds_left;
        logic              lamp_on;
        logic              buzzer_on;
        logic              display_update;
        logic              save_request;
    } ecc_result_t;

endpackage

// ===== rtl/exposure_countdown_controller_unit.sv =====
// Top level of the exposure lamp countdown controller: stream ports, APB registers, state.
// Depends on ecc_pkg and ecc_step.

// Each transfer on the input stream is one event: a millisecond tick that samples the
// encoder button, a one-second tick that counts the exposure down, an encoder capture that
// sets the time to (count/4)*15 seconds while idle, or a lid switch change. Every input
// transfer yields exactly one result transfer carrying the remaining seconds, the lamp
// and buzzer levels, and the display-update and settings-save pulses. An item waits in
// the input register and is then evaluated by combinational logic into the output
// register, from which its result is offered; a new item is taken in every cycle while
// the result stream is not stalled. The only limit on throughput is backpressure on
// the result stream. While the output register holds a waiting result, one more item
// can still enter the input register; once both are full, s_tready follows m_tready in
// the same cycle. The two configuration registers (debounce_ticks at byte address 0,
// long_press_ticks at byte address 4) are written over APB and should only be changed
// while no item is in flight.
module exposure_countdown_controller_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata bits: [0] button_pressed, [1] lid_open, [17:2] encoder_count, [23:18] zero.
    input  logic [ecc_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser bits: [1:0] kind.
    input  logic [1:0]                     s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata bits: [15:0] seconds_left, [16] lamp_on, [17] buzzer_on, [18] display_update,
    // [19] save_request, [23:20] zero.
    output logic [ecc_pkg::M_DATA_W-1:0]   m_tdata,
    // APB configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ecc_pkg::APB_AW-1:0]     paddr,
    input  logic [ecc_pkg::APB_DW-1:0]     pwdata,
    output logic [ecc_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import ecc_pkg::*;

    // Configuration registers.
    ecc_cfg_t    cfg_reg, cfg_next;
    ecc_reg_t    reg_sel;
    logic        cfg_wr;

    // Input register.
    logic        in_vld_reg, in_vld_next;
    ecc_item_t   in_item_reg, in_item_next;

    // Controller state.
    ecc_state_t  state_reg, state_next, state_step;

    // Output register.
    logic        out_vld_reg, out_vld_next;
    ecc_result_t out_res_reg, out_res_next, res_step;

    logic        s_xfer;
    logic        advance;

    // APB: always ready, write on the access phase. Only paddr[2] selects a register.
    assign pready  = 1'b1;
    assign reg_sel = ecc_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_DEBOUNCE:   cfg_next.debounce_ticks   = pwdata[CFG_W-1:0];
                REG_LONG_PRESS: cfg_next.long_press_ticks = pwdata[CFG_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_DEBOUNCE:   prdata = APB_DW'(cfg_reg.debounce_ticks);
            REG_LONG_PRESS: prdata = APB_DW'(cfg_reg.long_press_ticks);
            default:        prdata = '0;
        endcase
    end

    // The item in the input register moves on whenever the output register is free or is
    // being emptied in this cycle; the input register then refills in the same cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_item_next                = in_item_reg;
        in_item_next.kind           = ecc_kind_t'(s_tuser);
        in_item_next.button_pressed = s_tdata[0];
        in_item_next.lid_open       = s_tdata[1];
        in_item_next.encoder_count  = s_tdata[ENC_W+1:2];
        if (!s_xfer) begin
            in_item_next = in_item_reg;
        end
    end

    assign in_vld_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_vld_reg);

    ecc_step u_step (
        .state_i  (state_reg),
        .cfg_i    (cfg_reg),
        .item_i   (in_item_reg),
        .state_o  (state_step),
        .result_o (res_step)
    );

    // State is committed together with the result, so the following item sees it at once.
    assign state_next   = advance ? state_step : state_reg;
    assign out_res_next = advance ? res_step : out_res_reg;
    assign out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            in_vld_reg               <= 1'b0;
            out_vld_reg              <= 1'b0;
            state_reg                <= '0;
        end else begin
            cfg_reg     <= cfg_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            state_reg   <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_DATA_W'({out_res_reg.save_request, out_res_reg.display_update,
                                 out_res_reg.buzzer_on, out_res_reg.lamp_on,
                                 out_res_reg.seconds_left});

endmodule

// ===== rtl/ecc_step.sv =====
// Next-state and result logic for one item of the exposure countdown controller.
// Purely combinational; depends on ecc_pkg.
module ecc_step (
    input  ecc_pkg::ecc_state_t  state_i,
    input  ecc_pkg::ecc_cfg_t    cfg_i,
    input  ecc_pkg::ecc_item_t   item_i,
    output ecc_pkg::ecc_state_t  state_o,
    output ecc_pkg::ecc_result_t result_o
);
    import ecc_pkg::*;

    logic [PRESS_W-1:0] press_inc;
    logic [TIME_W-1:0]  secs_dec;
    logic [TIME_W-1:0]  enc_quarter;
    logic [TIME_W-1:0]  enc_time;
    logic               secs_nz;
    logic               disp;
    logic               save;
    ecc_state_t         nxt;

    assign press_inc   = state_i.press_ticks + PRESS_W'(1);
    assign secs_nz     = (state_i.seconds_count != '0);
    assign secs_dec    = secs_nz ? state_i.seconds_count - TIME_W'(1) : state_i.seconds_count;
    // (count / 4) * 15 computed as 16q - q, wrapping at 16 bits.
    assign enc_quarter = TIME_W'(item_i.encoder_count >> 2);
    assign enc_time    = (enc_quarter << 4) - enc_quarter;

    always_comb begin
        nxt  = state_i;
        disp = 1'b0;
        save = 1'b0;
        unique case (item_i.kind)
            KIND_MS_TICK: begin
                if (item_i.button_pressed) begin
                    nxt.press_ticks = press_inc;
                    if (state_i.press_ticks > {1'b0, cfg_i.long_press_ticks}) begin
                        nxt.running       = 1'b0;
                        nxt.buzzer_level  = 1'b0;
                        nxt.seconds_count = '0;
                        nxt.press_ticks   = '0;
                        disp              = 1'b1;
                    end
                end else begin
                    if (state_i.press_ticks > {1'b0, cfg_i.debounce_ticks} && secs_nz) begin
                        if (state_i.running) begin
                            nxt.running      = 1'b0;
                            nxt.buzzer_level = 1'b0;
                        end else begin
                            if (state_i.save_pending) begin
                                save             = 1'b1;
                                nxt.save_pending = 1'b0;
                            end
                            if (!item_i.lid_open) begin
                                nxt.running = 1'b1;
                            end
                        end
                    end
                    nxt.press_ticks = '0;
                end
            end
            KIND_SEC_TICK: begin
                if (state_i.running) begin
                    nxt.seconds_count = secs_dec;
                    if (secs_dec != '0) begin
                        if (secs_dec < WARN_SECONDS) begin
                            nxt.buzzer_level = !state_i.buzzer_level;
                        end
                    end else begin
                        nxt.running      = 1'b0;
                        nxt.buzzer_level = 1'b0;
                    end
                    disp = 1'b1;
                end
            end
            KIND_ENC_CAP: begin
                if (!state_i.running) begin
                    nxt.seconds_count = enc_time;
                    nxt.save_pending  = 1'b1;
                    disp              = 1'b1;
                end
            end
            KIND_LID: begin
                if (item_i.lid_open || state_i.running) begin
                    nxt.running      = 1'b0;
                    nxt.buzzer_level = 1'b0;
                end else if (secs_nz) begin
                    nxt.running = 1'b1;
                end
            end
            default: begin
                nxt = state_i;
            end
        endcase
    end

    assign state_o                 = nxt;
    assign result_o.seconds_left   = nxt.seconds_count;
    assign result_o.lamp_on        = nxt.running;
    assign result_o.buzzer_on      = nxt.buzzer_level;
    assign result_o.display_update = disp;
    assign result_o.save_request   = save;

endmodule
